/* rtl/core/pwirt_pkg.sv */
// Shared types and constants for the pulse-width IR byte transmitter.
package pwirt_pkg;

  localparam int unsigned BitsPerFrame = 8;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned TicksW       = 16;
  localparam int unsigned NumRegs      = 6;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned BitPosW      = $clog2(BitsPerFrame + 1);
  localparam int unsigned BitIdxW      = (BitsPerFrame > 1) ? $clog2(BitsPerFrame) : 1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } pwirt_cmd_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_START_BURST = 3'd0,
    REG_START_PAUSE = 3'd1,
    REG_ONE_BURST   = 3'd2,
    REG_ZERO_BURST  = 3'd3,
    REG_GAP         = 3'd4,
    REG_STOP_BURST  = 3'd5
  } pwirt_reg_e;

  localparam logic [TicksW-1:0] StartBurstRst = 16'd200;
  localparam logic [TicksW-1:0] StartPauseRst = 16'd100;
  localparam logic [TicksW-1:0] OneBurstRst   = 16'd145;
  localparam logic [TicksW-1:0] ZeroBurstRst  = 16'd95;
  localparam logic [TicksW-1:0] GapRst        = 16'd100;
  localparam logic [TicksW-1:0] StopBurstRst  = 16'd300;

  typedef struct packed {
    logic [TicksW-1:0] start_burst;
    logic [TicksW-1:0] start_pause;
    logic [TicksW-1:0] one_burst;
    logic [TicksW-1:0] zero_burst;
    logic [TicksW-1:0] gap;
    logic [TicksW-1:0] stop_burst;
  } pwirt_cfg_t;

  typedef struct packed {
    logic              carrier_on;
    logic [TicksW-1:0] phase_ticks;
    logic              busy_res;
    logic              finished;
  } pwirt_res_t;

endpackage

/* rtl/core/pwirt_seq.sv */
// Frame sequencer: phase state and next-phase selection for one event beat.
module pwirt_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  pwirt_pkg::pwirt_cmd_e cmd_i,
  input  logic [7:0]          data_byte_i,
  input  pwirt_pkg::pwirt_cfg_t cfg_i,
  output pwirt_pkg::pwirt_res_t res_o
);
  import pwirt_pkg::*;

  logic [ByteW-1:0]   shift_byte_q, shift_byte_d;
  logic [BitPosW-1:0] bit_pos_q, bit_pos_d;
  logic               in_pause_q, in_pause_d;
  logic               start_pend_q, start_pend_d;
  logic               stop_pend_q, stop_pend_d;
  logic               active_q, active_d;

  logic [ByteW-1:0]        sb_ld;
  logic [BitPosW-1:0]      bp_ld;
  logic                    ip_ld, sp_ld, stp_ld, act_ld;
  logic [BitsPerFrame-1:0] frame_bits;
  logic [BitPosW-1:0]      pos;
  logic                    data_bit;

  // Load a fresh frame on start, else carry the current state.
  always_comb begin
    if (cmd_i == CMD_START) begin
      sb_ld  = data_byte_i;
      bp_ld  = '0;
      ip_ld  = 1'b0;
      sp_ld  = 1'b1;
      stp_ld = 1'b1;
      act_ld = 1'b1;
    end else begin
      sb_ld  = shift_byte_q;
      bp_ld  = bit_pos_q;
      ip_ld  = in_pause_q;
      sp_ld  = start_pend_q;
      stp_ld = stop_pend_q;
      act_ld = active_q;
    end
  end

  // Bits above the byte are sent as zeros.
  assign frame_bits = BitsPerFrame'(sb_ld);
  assign pos        = BitPosW'(BitsPerFrame - 1) - bp_ld;
  assign data_bit   = frame_bits[pos[BitIdxW-1:0]];

  always_comb begin
    shift_byte_d = sb_ld;
    bit_pos_d    = bp_ld;
    in_pause_d   = ip_ld;
    start_pend_d = sp_ld;
    stop_pend_d  = stp_ld;
    active_d     = act_ld;
    res_o        = '0;
    if (act_ld) begin
      res_o.busy_res = 1'b1;
      priority if (sp_ld) begin
        in_pause_d = ~ip_ld;
        if (!ip_ld) begin
          res_o.carrier_on  = 1'b1;
          res_o.phase_ticks = cfg_i.start_burst;
        end else begin
          start_pend_d      = 1'b0;
          res_o.phase_ticks = cfg_i.start_pause;
        end
      end else if (bp_ld < BitPosW'(BitsPerFrame)) begin
        in_pause_d = ~ip_ld;
        if (!ip_ld) begin
          res_o.carrier_on  = 1'b1;
          res_o.phase_ticks = data_bit ? cfg_i.one_burst : cfg_i.zero_burst;
        end else begin
          bit_pos_d         = bp_ld + 1'b1;
          res_o.phase_ticks = cfg_i.gap;
        end
      end else if (stp_ld) begin
        in_pause_d = ~ip_ld;
        if (!ip_ld) begin
          res_o.carrier_on  = 1'b1;
          res_o.phase_ticks = cfg_i.stop_burst;
        end else begin
          stop_pend_d       = 1'b0;
          res_o.phase_ticks = cfg_i.gap;
        end
      end else begin
        // Frame done: drop back to idle.
        active_d       = 1'b0;
        start_pend_d   = 1'b1;
        stop_pend_d    = 1'b1;
        bit_pos_d      = '0;
        in_pause_d     = 1'b0;
        res_o.busy_res = 1'b0;
        res_o.finished = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_byte_q <= '0;
      bit_pos_q    <= '0;
      in_pause_q   <= 1'b0;
      start_pend_q <= 1'b1;
      stop_pend_q  <= 1'b1;
      active_q     <= 1'b0;
    end else if (accept_i) begin
      shift_byte_q <= shift_byte_d;
      bit_pos_q    <= bit_pos_d;
      in_pause_q   <= in_pause_d;
      start_pend_q <= start_pend_d;
      stop_pend_q  <= stop_pend_d;
      active_q     <= active_d;
    end
  end

endmodule

/* rtl/core/pulse_width_ir_byte_transmitter.sv */
// Top level of the pulse-width IR byte transmitter: config registers and result buffering.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   cmd_i, data_byte_i
//   out      output     out_valid_o / out_stall_i carrier_on_o, phase_ticks_o, busy_res_o,
//                                                 finished_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each beat is decoded in its accept cycle; its result is registered in out_q or skid_q.
// One beat per cycle is sustained; the output register plus a one-entry skid stage absorb
// a downstream stall, and in_stall_o rises only once the skid entry is occupied.
// Reset loads the default phase lengths and leaves the sequencer idle with no result pending.
module pulse_width_ir_byte_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        carrier_on_o,
  output logic [15:0] phase_ticks_o,
  output logic        busy_res_o,
  output logic        finished_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import pwirt_pkg::*;

  pwirt_cfg_t cfg_q;
  pwirt_res_t res;
  pwirt_res_t out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_fire, out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_burst <= StartBurstRst;
      cfg_q.start_pause <= StartPauseRst;
      cfg_q.one_burst   <= OneBurstRst;
      cfg_q.zero_burst  <= ZeroBurstRst;
      cfg_q.gap         <= GapRst;
      cfg_q.stop_burst  <= StopBurstRst;
    end else if (cfg_we_i) begin
      unique case (pwirt_reg_e'(cfg_idx_i))
        REG_START_BURST: cfg_q.start_burst <= cfg_data_i;
        REG_START_PAUSE: cfg_q.start_pause <= cfg_data_i;
        REG_ONE_BURST:   cfg_q.one_burst   <= cfg_data_i;
        REG_ZERO_BURST:  cfg_q.zero_burst  <= cfg_data_i;
        REG_GAP:         cfg_q.gap         <= cfg_data_i;
        REG_STOP_BURST:  cfg_q.stop_burst  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_fire   = out_valid_q & ~out_stall_i;

  pwirt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_fire),
    .cmd_i      (pwirt_cmd_e'(cmd_i)),
    .data_byte_i(data_byte_i),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers: advance from skid first, then from the new beat.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign carrier_on_o  = out_q.carrier_on;
  assign phase_ticks_o = out_q.phase_ticks;
  assign busy_res_o    = out_q.busy_res;
  assign finished_o    = out_q.finished;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && in_valid_i))
    else $error("skid filled without a stalled output");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (!carrier_on_o && !busy_res_o && phase_ticks_o == '0))
    else $error("finished beat carries a phase");

  a_carrier_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && carrier_on_o) |-> busy_res_o)
    else $error("carrier on outside a frame");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for the pulse-width IR byte transmitter: random frames checked against a phase predictor.
`timescale 1ns / 100ps

module tb_top;
  import pwirt_pkg::*;

  localparam int unsigned NextsPerFrame = 2 * BitsPerFrame + 4;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              cmd_i       = 1'b0;
  logic [ByteW-1:0]  data_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              carrier_on_o;
  logic [TicksW-1:0] phase_ticks_o;
  logic              busy_res_o;
  logic              finished_o;
  logic              cfg_we_i    = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i  = '0;
  logic [TicksW-1:0] cfg_data_i  = '0;

  pulse_width_ir_byte_transmitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .carrier_on_o (carrier_on_o),
    .phase_ticks_o(phase_ticks_o),
    .busy_res_o   (busy_res_o),
    .finished_o   (finished_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Phase sequencer predictor state
  logic [TicksW-1:0] phase_len [NumRegs];
  logic [ByteW-1:0]  frame_byte;
  int unsigned       bits_done;
  logic              in_gap;
  logic              start_due;
  logic              stop_due;
  logic              sending;

  pwirt_res_t expected_phases[$];
  int unsigned mismatches = 0;
  bit          idle_on = 1'b1;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;

  function automatic pwirt_res_t advance_phase();
    pwirt_res_t  r;
    int unsigned pos;
    logic        bit_val;
    r = '0;
    r.busy_res = 1'b1;
    if (start_due) begin
      if (!in_gap) begin
        in_gap = 1'b1;
        r.carrier_on = 1'b1;
        r.phase_ticks = phase_len[REG_START_BURST];
      end else begin
        in_gap = 1'b0;
        start_due = 1'b0;
        r.phase_ticks = phase_len[REG_START_PAUSE];
      end
    end else if (bits_done < BitsPerFrame) begin
      if (!in_gap) begin
        pos = BitsPerFrame - 1 - bits_done;
        bit_val = (pos < ByteW) ? frame_byte[pos] : 1'b0;
        in_gap = 1'b1;
        r.carrier_on = 1'b1;
        r.phase_ticks = bit_val ? phase_len[REG_ONE_BURST] : phase_len[REG_ZERO_BURST];
      end else begin
        in_gap = 1'b0;
        bits_done++;
        r.phase_ticks = phase_len[REG_GAP];
      end
    end else if (stop_due) begin
      if (!in_gap) begin
        in_gap = 1'b1;
        r.carrier_on = 1'b1;
        r.phase_ticks = phase_len[REG_STOP_BURST];
      end else begin
        in_gap = 1'b0;
        stop_due = 1'b0;
        r.phase_ticks = phase_len[REG_GAP];
      end
    end else begin
      sending = 1'b0;
      start_due = 1'b1;
      stop_due = 1'b1;
      bits_done = 0;
      in_gap = 1'b0;
      r.busy_res = 1'b0;
      r.finished = 1'b1;
    end
    return r;
  endfunction

  function automatic pwirt_res_t predict_phase(pwirt_cmd_e cmd, logic [ByteW-1:0] data);
    pwirt_res_t r;
    r = '0;
    if (cmd == CMD_START) begin
      frame_byte = data;
      bits_done = 0;
      in_gap = 1'b0;
      start_due = 1'b1;
      stop_due = 1'b1;
      sending = 1'b1;
      r = advance_phase();
    end else if (sending) begin
      r = advance_phase();
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pwirt_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_phases.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: carrier %0b ticks %0d busy %0b finished %0b", $time,
                 carrier_on_o, phase_ticks_o, busy_res_o, finished_o);
      end else begin
        exp_r = expected_phases.pop_front();
        if (carrier_on_o !== exp_r.carrier_on) begin
          mismatches++;
          $display("%0t: carrier_on expected %0b actual %0b", $time, exp_r.carrier_on,
                   carrier_on_o);
        end
        if (phase_ticks_o !== exp_r.phase_ticks) begin
          mismatches++;
          $display("%0t: phase_ticks expected %0d actual %0d", $time, exp_r.phase_ticks,
                   phase_ticks_o);
        end
        if (busy_res_o !== exp_r.busy_res) begin
          mismatches++;
          $display("%0t: busy_res expected %0b actual %0b", $time, exp_r.busy_res, busy_res_o);
        end
        if (finished_o !== exp_r.finished) begin
          mismatches++;
          $display("%0t: finished expected %0b actual %0b", $time, exp_r.finished, finished_o);
        end
      end
    end
  end

  // Downstream stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (stall_calm != 0) begin
        stall_calm--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        stall_left = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) stall_calm = $urandom_range(20, 80);
      end
    end
  end

  // Call at a falling edge; valid stays high on return unless a gap follows.
  task automatic send_event(input pwirt_cmd_e cmd, input logic [ByteW-1:0] data);
    in_valid_i = 1'b1;
    cmd_i = cmd;
    data_byte_i = data;
    do @(posedge clk_i); while (in_stall_o);
    expected_phases.push_back(predict_phase(cmd, data));
    @(negedge clk_i);
    if (idle_on) begin
      if (send_calm != 0) begin
        send_calm--;
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid_i = 1'b0;
        cmd_i = 1'($urandom);
        data_byte_i = ByteW'($urandom);
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(20, 80);
      end
    end
  endtask

  // Hold input until every outstanding result has drained
  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [TicksW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx < NumRegs) phase_len[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_lengths(input logic [TicksW-1:0] sb, input logic [TicksW-1:0] sp,
                              input logic [TicksW-1:0] ob, input logic [TicksW-1:0] zb,
                              input logic [TicksW-1:0] gp, input logic [TicksW-1:0] st);
    write_reg(REG_START_BURST, sb);
    write_reg(REG_START_PAUSE, sp);
    write_reg(REG_ONE_BURST, ob);
    write_reg(REG_ZERO_BURST, zb);
    write_reg(REG_GAP, gp);
    write_reg(REG_STOP_BURST, st);
  endtask

  function automatic logic [TicksW-1:0] pick_len();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return TicksW'($urandom);
    endcase
  endfunction

  task automatic run_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned cut;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_event(CMD_START, ByteW'($urandom));
        repeat (NextsPerFrame) send_event(CMD_NEXT, ByteW'($urandom));
        sent += NextsPerFrame + 1;
        if ($urandom_range(0, 3) == 0) send_event(CMD_NEXT, ByteW'($urandom));
      end else if (pick < 9) begin
        // abandon mid-frame; the next start restarts it
        cut = $urandom_range(0, NextsPerFrame - 1);
        send_event(CMD_START, ByteW'($urandom));
        repeat (cut) send_event(CMD_NEXT, ByteW'($urandom));
        sent += cut + 1;
      end else begin
        repeat ($urandom_range(1, 4)) send_event(pwirt_cmd_e'(1'($urandom)), ByteW'($urandom));
      end
    end
  endtask

  task automatic test_default_frame();
    send_event(CMD_NEXT, 8'hFF);
    send_event(CMD_START, 8'h00);
    repeat (2) send_event(CMD_NEXT, 8'h00);
    send_event(CMD_START, 8'hFF);
    repeat (NextsPerFrame) send_event(CMD_NEXT, 8'h00);
    send_event(CMD_NEXT, 8'h5A);
    drain();
  endtask

  task automatic test_zero_lengths();
    load_lengths('0, '0, '0, '0, '0, '0);
    // indexes past the last register must leave the lengths alone
    write_reg(RegIdxW'(NumRegs), 16'hBEEF);
    write_reg(RegIdxW'(NumRegs + 1), '1);
    run_frames(250);
    drain();
  endtask

  task automatic test_max_lengths();
    load_lengths('1, '1, '1, '1, '1, '1);
    run_frames(250);
    drain();
  endtask

  task automatic test_random_lengths();
    load_lengths(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
    run_frames(220);
    drain();
    run_frames(230);
    drain();
  endtask

  task automatic test_back_to_back();
    load_lengths(TicksW'($urandom), TicksW'($urandom), 16'h0001, 16'hFFFE,
                 TicksW'($urandom), 16'd300);
    idle_on = 1'b0;
    run_frames(400);
    drain();
  endtask

  initial begin
    phase_len[REG_START_BURST] = StartBurstRst;
    phase_len[REG_START_PAUSE] = StartPauseRst;
    phase_len[REG_ONE_BURST]   = OneBurstRst;
    phase_len[REG_ZERO_BURST]  = ZeroBurstRst;
    phase_len[REG_GAP]         = GapRst;
    phase_len[REG_STOP_BURST]  = StopBurstRst;
    frame_byte = '0;
    bits_done = 0;
    in_gap = 1'b0;
    start_due = 1'b1;
    stop_due = 1'b1;
    sending = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_frame();
    test_zero_lengths();
    test_max_lengths();
    test_random_lengths();
    test_back_to_back();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
